// ----- src/pwst_pkg.sv -----
// ----------------------------------------------------------------------------
// pwst_pkg
// Shared types and constants of the pulse-width symbol transmitter.
// ----------------------------------------------------------------------------
package pwst_pkg;

  // item commands
  localparam logic [1:0] CMD_BYTE = 2'd0;
  localparam logic [1:0] CMD_SYNC = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_SYNC_HIGH   = 3'd0;
  localparam logic [2:0] REG_ZERO_HIGH   = 3'd1;
  localparam logic [2:0] REG_ONE_HIGH    = 3'd2;
  localparam logic [2:0] REG_PERIOD      = 3'd3;
  localparam logic [2:0] REG_INVERT      = 3'd4;

  // register reset values
  localparam logic [3:0] SYNC_HIGH_RST = 4'd1;
  localparam logic [3:0] ZERO_HIGH_RST = 4'd3;
  localparam logic [3:0] ONE_HIGH_RST  = 4'd5;
  localparam logic [4:0] PERIOD_RST    = 5'd6;

  // period limits
  localparam logic [4:0] PERIOD_MIN = 5'd2;
  localparam logic [4:0] PERIOD_MAX = 5'd16;

  // symbols in a byte frame: sync plus eight bits
  localparam logic [3:0] FRAME_SYMBOLS = 4'd9;
  localparam logic [3:0] SYNC_SYMBOLS  = 4'd1;

  typedef enum logic [1:0] {
    KIND_SYNC = 2'd0,
    KIND_ZERO = 2'd1,
    KIND_ONE  = 2'd2
  } kind_e_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] byte_value;
  } item_t;

  typedef struct packed {
    logic line_level;
    logic accepted;
    logic busy_res;
  } result_t;

endpackage

// ----- src/pulse_width_symbol_transmitter_core.sv -----
// ----------------------------------------------------------------------------
// pulse_width_symbol_transmitter_core
// Pulse-width line encoder: queues byte and sync-only offers in one slot and
// plays them as sync plus bit symbols, one line level per tick item.
// ----------------------------------------------------------------------------
// output: the result of an accepted item is in the output register in the next cycle
// throughput: one item per cycle; the output register is reloaded in the cycle
//   it is taken, and the item channel stalls only while a result waits untaken
// reset: clears the output valid flag, the holding slot and the symbol counters,
//   and loads the configuration registers with their reset values
module pulse_width_symbol_transmitter_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  pwst_pkg::item_t    item,
  output logic               result_valid,
  input  logic               result_ready,
  output pwst_pkg::result_t  result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [4:0]         cfg_data
);

  // configuration
  logic [3:0] sync_high_ticks;
  logic [3:0] zero_high_ticks;
  logic [3:0] one_high_ticks;
  logic [4:0] symbol_period_ticks;
  logic       invert_line;

  // transmitter state
  logic                  pending_valid;
  logic                  pending_is_sync_only;
  logic [7:0]            pending_byte;
  logic [7:0]            active_bits;
  logic [3:0]            symbols_left;
  logic [3:0]            tick_in_symbol;
  pwst_pkg::kind_e_t     current_kind;
  logic                  line_high;

  logic                  pending_valid_next;
  logic                  pending_is_sync_only_next;
  logic [7:0]            pending_byte_next;
  logic [7:0]            active_bits_next;
  logic [3:0]            symbols_left_next;
  logic [3:0]            tick_in_symbol_next;
  pwst_pkg::kind_e_t     current_kind_next;
  logic                  line_high_next;
  logic                  accepted_next;

  logic                  item_fire;
  logic [4:0]            period_used;
  logic [3:0]            high_count;

  assign item_ready = !result_valid || result_ready;
  assign item_fire  = item_valid && item_ready;
  assign cfg_ready  = 1'b1;

  always_comb begin
    if (symbol_period_ticks < pwst_pkg::PERIOD_MIN) begin
      period_used = pwst_pkg::PERIOD_MIN;
    end else if (symbol_period_ticks > pwst_pkg::PERIOD_MAX) begin
      period_used = pwst_pkg::PERIOD_MAX;
    end else begin
      period_used = symbol_period_ticks;
    end
  end

  always_comb begin
    pending_valid_next        = pending_valid;
    pending_is_sync_only_next = pending_is_sync_only;
    pending_byte_next         = pending_byte;
    active_bits_next          = active_bits;
    symbols_left_next         = symbols_left;
    tick_in_symbol_next       = tick_in_symbol;
    current_kind_next         = current_kind;
    line_high_next            = line_high;
    accepted_next             = 1'b0;
    high_count                = sync_high_ticks;

    case (item.cmd)
      pwst_pkg::CMD_BYTE, pwst_pkg::CMD_SYNC: begin
        if (!pending_valid) begin
          pending_valid_next        = 1'b1;
          pending_is_sync_only_next = (item.cmd == pwst_pkg::CMD_SYNC);
          pending_byte_next         = (item.cmd == pwst_pkg::CMD_BYTE) ?
                                      item.byte_value : 8'd0;
          accepted_next             = 1'b1;
        end
      end
      pwst_pkg::CMD_TICK: begin
        // start the queued frame when the line is idle
        if (symbols_left == 4'd0 && pending_valid) begin
          active_bits_next    = pending_byte;
          symbols_left_next   = pending_is_sync_only ? pwst_pkg::SYNC_SYMBOLS :
                                                       pwst_pkg::FRAME_SYMBOLS;
          tick_in_symbol_next = 4'd0;
          current_kind_next   = pwst_pkg::KIND_SYNC;
          pending_valid_next  = 1'b0;
        end
        case (current_kind_next)
          pwst_pkg::KIND_ZERO: high_count = zero_high_ticks;
          pwst_pkg::KIND_ONE:  high_count = one_high_ticks;
          default:             high_count = sync_high_ticks;
        endcase
        if (symbols_left_next == 4'd0) begin
          line_high_next = 1'b0;
        end else begin
          line_high_next = (tick_in_symbol_next < high_count);
          // end of symbol: step to the next bit, msb first
          if ({1'b0, tick_in_symbol_next} + 5'd1 >= period_used) begin
            tick_in_symbol_next = 4'd0;
            symbols_left_next   = symbols_left_next - 4'd1;
            if (symbols_left_next != 4'd0) begin
              current_kind_next = active_bits_next[7] ? pwst_pkg::KIND_ONE :
                                                        pwst_pkg::KIND_ZERO;
              active_bits_next  = {active_bits_next[6:0], 1'b0};
            end
          end else begin
            tick_in_symbol_next = tick_in_symbol_next + 4'd1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_high_ticks     <= pwst_pkg::SYNC_HIGH_RST;
      zero_high_ticks     <= pwst_pkg::ZERO_HIGH_RST;
      one_high_ticks      <= pwst_pkg::ONE_HIGH_RST;
      symbol_period_ticks <= pwst_pkg::PERIOD_RST;
      invert_line         <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pwst_pkg::REG_SYNC_HIGH: sync_high_ticks     <= cfg_data[3:0];
        pwst_pkg::REG_ZERO_HIGH: zero_high_ticks     <= cfg_data[3:0];
        pwst_pkg::REG_ONE_HIGH:  one_high_ticks      <= cfg_data[3:0];
        pwst_pkg::REG_PERIOD:    symbol_period_ticks <= cfg_data;
        pwst_pkg::REG_INVERT:    invert_line         <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_valid        <= 1'b0;
      pending_is_sync_only <= 1'b0;
      pending_byte         <= 8'd0;
      active_bits          <= 8'd0;
      symbols_left         <= 4'd0;
      tick_in_symbol       <= 4'd0;
      current_kind         <= pwst_pkg::KIND_SYNC;
      line_high            <= 1'b0;
    end else if (item_fire) begin
      pending_valid        <= pending_valid_next;
      pending_is_sync_only <= pending_is_sync_only_next;
      pending_byte         <= pending_byte_next;
      active_bits          <= active_bits_next;
      symbols_left         <= symbols_left_next;
      tick_in_symbol       <= tick_in_symbol_next;
      current_kind         <= current_kind_next;
      line_high            <= line_high_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (item_fire) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_fire) begin
      result.line_level <= line_high_next ^ invert_line;
      result.accepted   <= accepted_next;
      result.busy_res   <= (symbols_left_next != 4'd0) || pending_valid_next;
    end
  end

endmodule

// ----- src/pwst_checker.sv -----
// ----------------------------------------------------------------------------
// pwst_checker
// Port-level checks of the pulse-width symbol transmitter, bound to the core.
// ----------------------------------------------------------------------------
module pwst_checker (
  input logic               clk,
  input logic               rst,
  input logic               item_valid,
  input logic               item_ready,
  input pwst_pkg::item_t    item,
  input logic               result_valid,
  input logic               result_ready,
  input pwst_pkg::result_t  result
);

  // a waiting result holds until taken
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // every accepted item produces a result in the next cycle
  a_one_cycle: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> result_valid)
    else $error("result missing after accepted transaction");

  // ticks never report an accepted offer
  a_tick_no_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item.cmd == pwst_pkg::CMD_TICK
    |=> !result.accepted)
    else $error("tick reported as accepted offer");

  // after any offer the slot is full, so the transmitter is busy
  a_offer_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready &&
    (item.cmd == pwst_pkg::CMD_BYTE || item.cmd == pwst_pkg::CMD_SYNC)
    |=> result.busy_res)
    else $error("offer left transmitter idle");

endmodule

bind pulse_width_symbol_transmitter_core pwst_checker u_pwst_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .item         (item),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Checks the pulse-width symbol transmitter core against a cycle-free model of
// its slot, symbol counters and line level. Offers and ticks are driven with
// random gaps and result stalls over several timing settings. Every result is
// compared field by field in order of arrival.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // command value the block ignores
  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int PHASES = 6;
  localparam int unsigned PHASE_ITEMS = 258;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              item_valid = 1'b0;
  logic              item_ready;
  pwst_pkg::item_t   item = '0;
  logic              result_valid;
  logic              result_ready = 1'b0;
  pwst_pkg::result_t result;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [2:0]        cfg_index = '0;
  logic [4:0]        cfg_data = '0;

  pulse_width_symbol_transmitter_core dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // register copies
  logic [3:0] sync_high_cfg = pwst_pkg::SYNC_HIGH_RST;
  logic [3:0] zero_high_cfg = pwst_pkg::ZERO_HIGH_RST;
  logic [3:0] one_high_cfg  = pwst_pkg::ONE_HIGH_RST;
  logic [4:0] period_cfg    = pwst_pkg::PERIOD_RST;
  logic       invert_cfg    = 1'b0;

  // transmitter state
  logic              slot_full = 1'b0;
  logic              slot_sync_only = 1'b0;
  logic [7:0]        slot_byte = '0;
  logic [7:0]        bits_to_send = '0;
  logic [3:0]        symbols_to_play = '0;
  logic [3:0]        tick_count = '0;
  pwst_pkg::kind_e_t symbol_kind = pwst_pkg::KIND_SYNC;
  logic              line_high = 1'b0;

  pwst_pkg::item_t   queued_items[$];
  pwst_pkg::result_t expected_line_results[$];
  logic              item_taken = 1'b0;
  int unsigned       sender_idle_pct = 27;
  int unsigned       receiver_idle_pct = 82;
  int unsigned       mismatches = 0;
  int unsigned       cycle_count = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int unsigned effective_period();
    int unsigned p;
    p = 32'(period_cfg);
    if (p < 32'(pwst_pkg::PERIOD_MIN)) p = 32'(pwst_pkg::PERIOD_MIN);
    if (p > 32'(pwst_pkg::PERIOD_MAX)) p = 32'(pwst_pkg::PERIOD_MAX);
    return p;
  endfunction

  // advances the transmitter by one item and returns the level, acceptance and busy flag it leaves
  function automatic pwst_pkg::result_t predict_line_result(pwst_pkg::item_t it);
    pwst_pkg::result_t r;
    logic [3:0]        high_ticks;
    r = '0;
    if (it.cmd == pwst_pkg::CMD_BYTE || it.cmd == pwst_pkg::CMD_SYNC) begin
      if (!slot_full) begin
        slot_full = 1'b1;
        slot_sync_only = (it.cmd == pwst_pkg::CMD_SYNC);
        slot_byte = (it.cmd == pwst_pkg::CMD_BYTE) ? it.byte_value : 8'h00;
        r.accepted = 1'b1;
      end
    end else if (it.cmd == pwst_pkg::CMD_TICK) begin
      // next frame starts on the first tick after the previous one ends
      if (symbols_to_play == 0 && slot_full) begin
        bits_to_send = slot_byte;
        symbols_to_play = slot_sync_only ? pwst_pkg::SYNC_SYMBOLS :
                                           pwst_pkg::FRAME_SYMBOLS;
        tick_count = '0;
        symbol_kind = pwst_pkg::KIND_SYNC;
        slot_full = 1'b0;
      end
      if (symbols_to_play == 0) begin
        line_high = 1'b0;
      end else begin
        case (symbol_kind)
          pwst_pkg::KIND_ZERO: high_ticks = zero_high_cfg;
          pwst_pkg::KIND_ONE:  high_ticks = one_high_cfg;
          default:             high_ticks = sync_high_cfg;
        endcase
        line_high = (tick_count < high_ticks);
        if (int'(tick_count) + 1 >= effective_period()) begin
          tick_count = '0;
          symbols_to_play = symbols_to_play - 4'd1;
          if (symbols_to_play != 0) begin
            symbol_kind = bits_to_send[7] ? pwst_pkg::KIND_ONE : pwst_pkg::KIND_ZERO;
            bits_to_send = bits_to_send << 1;
          end
        end else begin
          tick_count = tick_count + 4'd1;
        end
      end
    end
    r.line_level = line_high ^ invert_cfg;
    r.busy_res = (symbols_to_play != 0) || slot_full;
    return r;
  endfunction

  // driver: items and result stalls change on the falling edge
  always @(negedge clk) begin
    if (!rst) begin
      if (!item_valid || item_taken) begin
        if (queued_items.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          item_valid <= 1'b1;
          item <= queued_items.pop_front();
        end else begin
          item_valid <= 1'b0;
        end
      end
      result_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end
  end

  // monitor: both channels sampled on the rising edge
  always @(posedge clk) begin
    pwst_pkg::result_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end else begin
      item_taken = !rst && item_valid && item_ready;
      if (!rst && result_valid && result_ready) begin
        if (expected_line_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result transaction: level %0b acc %0b busy %0b",
                     result.line_level, result.accepted, result.busy_res);
        end else begin
          want = expected_line_results.pop_front();
          if (result !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch at cycle %0d: expected level %0b acc %0b busy %0b,",
                        " got %0b %0b %0b"},
                       cycle_count, want.line_level, want.accepted, want.busy_res,
                       result.line_level, result.accepted, result.busy_res);
          end
        end
      end
      if (item_taken) expected_line_results.push_back(predict_line_result(item));
    end
  end

  task automatic queue_item(input logic [1:0] cmd, input logic [7:0] value);
    pwst_pkg::item_t it;
    it.cmd = cmd;
    it.byte_value = value;
    queued_items.push_back(it);
  endtask

  // waits until every item is sent and every result is back
  task automatic wait_idle();
    do begin
      @(posedge clk);
      #1;
    end while (queued_items.size() != 0 || item_valid || expected_line_results.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [4:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      pwst_pkg::REG_SYNC_HIGH: sync_high_cfg = value[3:0];
      pwst_pkg::REG_ZERO_HIGH: zero_high_cfg = value[3:0];
      pwst_pkg::REG_ONE_HIGH:  one_high_cfg = value[3:0];
      pwst_pkg::REG_PERIOD:    period_cfg = value;
      pwst_pkg::REG_INVERT:    invert_cfg = value[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly an offer followed by a run of ticks, with some noise in between
  task automatic queue_random_traffic(input int unsigned count);
    int unsigned queued;
    int unsigned run;
    int unsigned pick;
    queued = 0;
    while (queued < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        queue_item(($urandom_range(0, 99) < 80) ? pwst_pkg::CMD_BYTE : pwst_pkg::CMD_SYNC,
                   8'($urandom_range(0, 255)));
        run = $urandom_range(1, 10 * effective_period());
        // keep the phase close to its item budget
        if (run + 1 > count - queued) run = count - queued - 1;
        repeat (run) queue_item(pwst_pkg::CMD_TICK, 8'($urandom_range(0, 255)));
        queued += run + 1;
      end else if (pick < 88) begin
        queue_item(CMD_NONE, 8'($urandom_range(0, 255)));
      end else if (pick < 94) begin
        queue_item(($urandom_range(0, 1) == 0) ? pwst_pkg::CMD_BYTE : pwst_pkg::CMD_SYNC,
                   8'($urandom_range(0, 255)));
        queued++;
      end else begin
        queue_item(pwst_pkg::CMD_TICK, 8'($urandom_range(0, 255)));
        queued++;
      end
    end
  endtask

  initial begin
    logic [4:0] sync_set[PHASES]   = '{5'd1, 5'd0,  5'd15, 5'd2, 5'd3,  5'd4};
    logic [4:0] zero_set[PHASES]   = '{5'd3, 5'd15, 5'd0,  5'd5, 5'd1,  5'd8};
    logic [4:0] one_set[PHASES]    = '{5'd5, 5'd1,  5'd7,  5'd9, 5'd12, 5'd11};
    logic [4:0] period_set[PHASES] = '{5'd6, 5'd2,  5'd16, 5'd0, 5'd31, 5'd9};
    logic [4:0] invert_set[PHASES] = '{5'd0, 5'd1,  5'd0,  5'd1, 5'd0,  5'd1};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: idle tick, full-slot refusals, ignored command, offer while playing
    queue_item(pwst_pkg::CMD_TICK, 8'h00);
    queue_item(pwst_pkg::CMD_BYTE, 8'hA5);
    queue_item(pwst_pkg::CMD_BYTE, 8'hFF);
    queue_item(pwst_pkg::CMD_SYNC, 8'h00);
    queue_item(CMD_NONE, 8'hFF);
    repeat (9) queue_item(pwst_pkg::CMD_TICK, 8'hFF);
    queue_item(pwst_pkg::CMD_SYNC, 8'h5A);
    queue_item(pwst_pkg::CMD_BYTE, 8'h00);
    repeat (3) queue_item(pwst_pkg::CMD_TICK, 8'h00);

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        wait_idle();
        write_reg(pwst_pkg::REG_SYNC_HIGH, sync_set[p]);
        write_reg(pwst_pkg::REG_ZERO_HIGH, zero_set[p]);
        write_reg(pwst_pkg::REG_ONE_HIGH, one_set[p]);
        write_reg(pwst_pkg::REG_PERIOD, period_set[p]);
        write_reg(pwst_pkg::REG_INVERT, invert_set[p]);
      end
      if (p < 2) begin
        sender_idle_pct = 27;
        receiver_idle_pct = 82;
      end else if (p < 4) begin
        sender_idle_pct = 82;
        receiver_idle_pct = 27;
      end else begin
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
      end
      if (p == 1) begin
        // sender holds off until every queued item has been answered
        queue_random_traffic(PHASE_ITEMS / 2);
        wait_idle();
        queue_random_traffic(PHASE_ITEMS / 2);
      end else begin
        queue_random_traffic(PHASE_ITEMS);
      end
    end

    wait_idle();
    repeat (5) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/pwst_pkg.sv
src/pulse_width_symbol_transmitter_core.sv
src/pwst_checker.sv
tb/sv/testbench.sv
